// ----- design/mnqr_pkg.sv -----
// shared types, constants and the answer byte table for the mdns responder
package mnqr_pkg;

  localparam int unsigned POS_W      = 6;
  localparam int unsigned NAME_LEN   = 16;
  localparam int unsigned ANSWER_LEN = 42;

  // payload byte positions
  localparam logic [POS_W-1:0] POS_ID_HI    = 6'd0;
  localparam logic [POS_W-1:0] POS_ID_LO    = 6'd1;
  localparam logic [POS_W-1:0] POS_FLAGS    = 6'd2;
  localparam logic [POS_W-1:0] POS_NAME_LO  = 6'd12;
  localparam logic [POS_W-1:0] POS_NAME_HI  = 6'd27;
  localparam logic [POS_W-1:0] POS_QTYPE_HI = 6'd28;
  localparam logic [POS_W-1:0] POS_QTYPE_LO = 6'd29;
  localparam logic [POS_W-1:0] POS_STOP     = 6'd30;

  // answer byte positions
  localparam logic [POS_W-1:0] ANS_ID_HI    = 6'd0;
  localparam logic [POS_W-1:0] ANS_ID_LO    = 6'd1;
  localparam logic [POS_W-1:0] ANS_FLAGS_HI = 6'd2;
  localparam logic [POS_W-1:0] ANS_ANCNT_LO = 6'd7;
  localparam logic [POS_W-1:0] ANS_NAME_LO  = 6'd12;
  localparam logic [POS_W-1:0] ANS_NAME_HI  = 6'd27;
  localparam logic [POS_W-1:0] ANS_TYPE_LO  = 6'd29;
  localparam logic [POS_W-1:0] ANS_CLASS_HI = 6'd30;
  localparam logic [POS_W-1:0] ANS_CLASS_LO = 6'd31;
  localparam logic [POS_W-1:0] ANS_TTL_LO   = 6'd35;
  localparam logic [POS_W-1:0] ANS_RDLEN_LO = 6'd37;
  localparam logic [POS_W-1:0] ANS_IP_B3    = 6'd38;
  localparam logic [POS_W-1:0] ANS_IP_B2    = 6'd39;
  localparam logic [POS_W-1:0] ANS_IP_B1    = 6'd40;
  localparam logic [POS_W-1:0] ANS_IP_B0    = 6'd41;
  localparam logic [POS_W-1:0] ANS_LAST     = 6'(ANSWER_LEN - 1);

  localparam logic [7:0] FLAGS_HI  = 8'h84;
  localparam logic [7:0] ANCNT_LO  = 8'h01;
  localparam logic [7:0] QTYPE_HI  = 8'h00;
  localparam logic [7:0] TYPE_A    = 8'h01;
  localparam logic [7:0] CLASS_HI  = 8'h80;
  localparam logic [7:0] CLASS_LO  = 8'h01;
  localparam logic [7:0] TTL_LO    = 8'h78;
  localparam logic [7:0] RDLEN_LO  = 8'h04;

  // encoded host name, two labels and the root
  localparam logic [7:0] HOST_NAME [NAME_LEN] = '{
    8'h08, 8'h63, 8'h68, 8'h69, 8'h6d, 8'h61, 8'h65, 8'h72, 8'h61,
    8'h05, 8'h6c, 8'h6f, 8'h63, 8'h61, 8'h6c, 8'h00
  };

  // register address map
  localparam int unsigned ADDR_W = 2;
  localparam logic [ADDR_W-1:0] REG_IPV4 = 2'd0;

  typedef struct packed {
    logic        fire;
    logic [15:0] id;
  } trig_t;

  function automatic logic [7:0] answer_byte(input logic [POS_W-1:0] idx,
                                             input logic [15:0] id,
                                             input logic [31:0] ip);
    logic [3:0] noff;
    logic [7:0] b;
    noff = idx[3:0] - ANS_NAME_LO[3:0];
    b    = 8'h00;
    if (idx inside {[ANS_NAME_LO:ANS_NAME_HI]}) begin
      b = HOST_NAME[noff];
    end else begin
      case (idx)
        ANS_ID_HI:    b = id[15:8];
        ANS_ID_LO:    b = id[7:0];
        ANS_FLAGS_HI: b = FLAGS_HI;
        ANS_ANCNT_LO: b = ANCNT_LO;
        ANS_TYPE_LO:  b = TYPE_A;
        ANS_CLASS_HI: b = CLASS_HI;
        ANS_CLASS_LO: b = CLASS_LO;
        ANS_TTL_LO:   b = TTL_LO;
        ANS_RDLEN_LO: b = RDLEN_LO;
        ANS_IP_B3:    b = ip[31:24];
        ANS_IP_B2:    b = ip[23:16];
        ANS_IP_B1:    b = ip[15:8];
        ANS_IP_B0:    b = ip[7:0];
        default:      b = 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

// ----- design/mnqr_rx_if.sv -----
// receive byte stream interface
interface mnqr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       rx_last;

  modport source (output valid, output rx_byte, output rx_last, input ready);
  modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

// ----- design/mnqr_tx_if.sv -----
// answer byte stream interface
interface mnqr_tx_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_last;

  modport source (output valid, output tx_byte, output tx_last, input ready);
  modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

// ----- design/mnqr_parse.sv -----
// query parser: tracks byte position, id and match, raises the answer trigger
module mnqr_parse
  import mnqr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mnqr_rx_if.sink     rx,
  input  logic        emit_idle,
  output trig_t       trig
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      tid_r, tid_nxt;
  logic             match_r, match_nxt;
  logic             fin_r, fin_nxt;
  trig_t            trig_r, trig_nxt;

  logic [POS_W-1:0] eff_pos;
  logic [15:0]      eff_tid;
  logic             eff_match;
  logic [3:0]       name_idx;
  logic             chk_match;
  logic             accept;

  // a finished payload restarts on the next byte
  assign eff_pos   = fin_r ? '0 : pos_r;
  assign eff_tid   = fin_r ? '0 : tid_r;
  assign eff_match = fin_r ? 1'b1 : match_r;
  assign name_idx  = eff_pos[3:0] - POS_NAME_LO[3:0];

  // the qtype low byte may start an answer, so it waits for a free emitter
  assign rx.ready = (eff_pos != POS_QTYPE_LO) || emit_idle;
  assign accept   = rx.valid && rx.ready;

  always_comb begin
    chk_match = eff_match;
    tid_nxt   = eff_tid;
    case (eff_pos)
      POS_ID_HI:    tid_nxt = {rx.rx_byte, eff_tid[7:0]};
      POS_ID_LO:    tid_nxt = {eff_tid[15:8], rx.rx_byte};
      POS_FLAGS:    if (rx.rx_byte[7]) chk_match = 1'b0;
      POS_QTYPE_HI: if (rx.rx_byte != QTYPE_HI) chk_match = 1'b0;
      POS_QTYPE_LO: if (rx.rx_byte != TYPE_A) chk_match = 1'b0;
      default: begin
        if ((eff_pos inside {[POS_NAME_LO:POS_NAME_HI]}) &&
            (rx.rx_byte != HOST_NAME[name_idx])) begin
          chk_match = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    match_nxt = match_r;
    fin_nxt   = fin_r;
    trig_nxt  = '{fire: 1'b0, id: trig_r.id};
    if (accept) begin
      pos_nxt   = (eff_pos < POS_STOP) ? eff_pos + 6'd1 : eff_pos;
      match_nxt = chk_match;
      fin_nxt   = rx.rx_last;
      if ((eff_pos == POS_QTYPE_LO) && chk_match) begin
        trig_nxt = '{fire: 1'b1, id: tid_nxt};
      end
    end
  end

  always_ff @(posedge clk) begin
    trig_r.id <= trig_nxt.id;
    if (!rst_n) begin
      pos_r       <= '0;
      tid_r       <= '0;
      match_r     <= 1'b1;
      fin_r       <= 1'b0;
      trig_r.fire <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      tid_r       <= accept ? tid_nxt : tid_r;
      match_r     <= match_nxt;
      fin_r       <= fin_nxt;
      trig_r.fire <= trig_nxt.fire;
    end
  end

  assign trig = trig_r;

endmodule

// ----- design/mnqr_emit.sv -----
// answer generator: counts out the 42 answer bytes into an output register
module mnqr_emit
  import mnqr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  trig_t       trig,
  input  logic [31:0] ipv4,
  output logic        emit_idle,
  mnqr_tx_if.source   tx
);

  logic             busy_r;
  logic [POS_W-1:0] cnt_r;
  logic [15:0]      id_r;
  logic             oval_r;
  logic [7:0]       obyte_r;
  logic             olast_r;
  logic             load;

  // free next cycle only if nothing is running and no trigger is in flight
  assign emit_idle = !busy_r && !trig.fire;
  assign load      = busy_r && (!oval_r || tx.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      oval_r <= 1'b0;
    end else begin
      if (trig.fire) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (load) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == ANS_LAST) busy_r <= 1'b0;
      end
      if (load) begin
        oval_r <= 1'b1;
      end else if (tx.ready) begin
        oval_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (trig.fire) id_r <= trig.id;
    if (load) begin
      obyte_r <= answer_byte(cnt_r, id_r, ipv4);
      olast_r <= (cnt_r == ANS_LAST);
    end
  end

  assign tx.valid   = oval_r;
  assign tx.tx_byte = obyte_r;
  assign tx.tx_last = olast_r;

  // a new answer only starts on an idle generator
  a_trig_idle: assert property (@(posedge clk) disable iff (!rst_n)
    trig.fire |-> !busy_r)
    else $error("answer trigger while busy");

  // the counter never runs past the last answer byte
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r <= ANS_LAST))
    else $error("answer counter out of range");

  // the burst ends only after the final byte has been loaded
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> (oval_r && olast_r))
    else $error("answer ended without last byte");

endmodule

// ----- design/mdns_name_query_responder.sv -----
// top level of the mdns a-record query responder
//
//  channel  | dir | transaction payload       | handshake
//  ---------+-----+---------------------------+--------------------------------
//  in_ch    | in  | rx_byte[7:0], rx_last     | valid & ready
//  out_ch   | out | tx_byte[7:0], tx_last     | valid & ready
//  cfg apb  | in  | paddr, pwdata / prdata    | psel & penable & pwrite & pready
//
// one received byte per cycle unless in_ch stalls; an accepted matching qtype byte sets the
// trigger register, the generator starts in the cycle after, and each answer byte is loaded
// into the output register before it is sent; 42 bytes, one per cycle while ready is high
// in_ch stalls only on the qtype low byte while a trigger is pending or the previous answer
// is still being loaded into the output register
// rst_n is synchronous, active low; it clears parser, generator and ipv4 reg
module mdns_name_query_responder
  import mnqr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  mnqr_rx_if.sink           in_ch,
  mnqr_tx_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0] ipv4_r;
  logic        reg_wr;
  trig_t       trig;
  logic        emit_idle;

  // apb register: own ipv4 address, always ready
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready && (paddr == REG_IPV4);
  assign prdata = (paddr == REG_IPV4) ? ipv4_r : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipv4_r <= 32'h0;
    end else if (reg_wr) begin
      ipv4_r <= pwdata;
    end
  end

  // header, flags, name and qtype checks
  mnqr_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx        (in_ch),
    .emit_idle (emit_idle),
    .trig      (trig)
  );

  // answer burst generation
  mnqr_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .trig      (trig),
    .ipv4      (ipv4_r),
    .emit_idle (emit_idle),
    .tx        (out_ch)
  );

endmodule
